>>> hw/rtl/hsmd_pkg.sv
// Shared types, constants and saturation helpers for the spring-mass-damper renderer.
package hsmd_pkg;

    // Register file layout
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned REG_W     = 31;
    localparam int unsigned Q_W       = 32;
    localparam int unsigned WIDE_W    = 49;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STIFFNESS = 2'd0,
        CFG_MASS      = 2'd1,
        CFG_TIMESTEP  = 2'd2
    } t_cfg_idx;

    localparam logic [REG_W-1:0] STIFFNESS_RST = 31'd1165230;
    localparam logic [REG_W-1:0] MASS_RST      = 31'd29511;
    localparam logic [REG_W-1:0] TIMESTEP_RST  = 31'd66;

    // Divider: 48-bit numerator (torque << 16), two quotient bits per cycle
    localparam int unsigned DIV_NUM_W   = 48;
    localparam int unsigned DIV_FRAC_W  = 16;
    localparam int unsigned DIV_RADIX_W = 2;
    localparam int unsigned DIV_STEPS   = DIV_NUM_W / DIV_RADIX_W;
    localparam int unsigned DIV_CNT_W   = $clog2(DIV_STEPS);

    localparam logic signed [WIDE_W-1:0] SAT_HI = 49'sd2147483647;
    localparam logic signed [WIDE_W-1:0] SAT_LO = -49'sd2147483648;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_KT,
        ST_SPR,
        ST_DMP,
        ST_TRQ,
        ST_DST,
        ST_DIV,
        ST_DV,
        ST_DVC,
        ST_HF,
        ST_UPD,
        ST_OUT
    } t_state;

    // Clamp a wide signed value to the signed 32-bit range
    function automatic logic signed [Q_W-1:0] f_sat32(input logic signed [WIDE_W-1:0] x);
        logic signed [Q_W-1:0] res;
        if (x > SAT_HI) begin
            res = 32'sh7FFF_FFFF;
        end else if (x < SAT_LO) begin
            res = 32'sh8000_0000;
        end else begin
            res = x[Q_W-1:0];
        end
        return res;
    endfunction

    function automatic logic signed [Q_W-1:0] f_sat_add(input logic signed [Q_W-1:0] a,
                                                        input logic signed [Q_W-1:0] b);
        logic signed [WIDE_W-1:0] wa;
        logic signed [WIDE_W-1:0] wb;
        wa = {{(WIDE_W-Q_W){a[Q_W-1]}}, a};
        wb = {{(WIDE_W-Q_W){b[Q_W-1]}}, b};
        return f_sat32(wa + wb);
    endfunction

    function automatic logic signed [Q_W-1:0] f_sat_sub(input logic signed [Q_W-1:0] a,
                                                        input logic signed [Q_W-1:0] b);
        logic signed [WIDE_W-1:0] wa;
        logic signed [WIDE_W-1:0] wb;
        wa = {{(WIDE_W-Q_W){a[Q_W-1]}}, a};
        wb = {{(WIDE_W-Q_W){b[Q_W-1]}}, b};
        return f_sat32(wa - wb);
    endfunction

endpackage

>>> hw/rtl/haptic_spring_mass_damper_tunable.sv
// Spring-mass-damper haptic renderer: one torque per wheel sample from a simulated mass.
//
// Each sample (angle and velocity, signed Q16.16) yields one torque
// K*(angle - mass position) + K*T*(velocity - mass speed), saturated to 32 bits, after which
// the virtual mass advances by constant-acceleration integration with a = torque / M.
// Stiffness, mass and timestep must be written through the register port only while the block is
// idle; the block itself does not enforce this. A zero mass acts as 1 LSB. Each sample runs
// through sequencer steps around the single shared multiplier (six products, issued one at a
// time, each registered in the multiplier and saturated as it is read), then through the
// divider, which retires two quotient bits a cycle over a 48-bit numerator and flags completion
// as the last quotient bits are registered. The input is ready again in the same cycle that the
// result appears in the output register, so a new sample is taken only once the previous result
// has been loaded; a waiting result never blocks the next sample from being taken, but holds the
// following result until the output register is free.
module haptic_spring_mass_damper_tunable (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Sample input
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [63:0]                       i_s_tdata,   // [31:0] wheel_angle, [63:32] wheel_velocity
    // Torque output
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [31:0]                       o_m_tdata,   // [31:0] drive_torque
    // Register write port
    input  logic                              i_cfg_we,
    input  logic [hsmd_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [hsmd_pkg::REG_W-1:0]        i_cfg_wdata
);

    localparam int unsigned QW = hsmd_pkg::Q_W;

    hsmd_pkg::t_state r_state;
    hsmd_pkg::t_state n_state;

    logic [hsmd_pkg::REG_W-1:0] r_stiff;
    logic [hsmd_pkg::REG_W-1:0] r_mass;
    logic [hsmd_pkg::REG_W-1:0] r_tstep;

    logic signed [QW-1:0] r_pos;
    logic signed [QW-1:0] r_speed;
    logic signed [QW-1:0] r_da;
    logic signed [QW-1:0] r_dv;
    logic signed [QW-1:0] r_damp;
    logic signed [QW-1:0] r_spring;
    logic signed [QW-1:0] r_torque;
    logic signed [QW-1:0] r_vterm;
    logic signed [QW-1:0] r_acc;
    logic signed [QW-1:0] r_dvel;

    logic                 r_m_tvalid;
    logic [QW-1:0]        r_m_tdata;

    logic signed [QW-1:0] in_angle;
    logic signed [QW-1:0] in_vel;
    logic                 s_accept;
    logic                 out_free;

    logic signed [QW-1:0]       mul_a;
    logic [hsmd_pkg::REG_W-1:0] mul_b;
    logic                       mul_half;
    logic signed [QW-1:0]       mul_res;

    logic                       div_start;
    logic                       div_done;
    logic signed [QW-1:0]       div_quo;
    logic [hsmd_pkg::REG_W-1:0] mass_eff;

    assign in_angle = $signed(i_s_tdata[31:0]);
    assign in_vel   = $signed(i_s_tdata[63:32]);
    assign s_accept = i_s_tvalid && o_s_tready;
    assign out_free = !r_m_tvalid || i_m_tready;
    assign mass_eff = (r_mass == '0) ? hsmd_pkg::REG_W'(1) : r_mass;

    hsmd_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .i_half (mul_half),
        .o_res  (mul_res)
    );

    hsmd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_torque),
        .i_den   (mass_eff),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stiff <= hsmd_pkg::STIFFNESS_RST;
            r_mass  <= hsmd_pkg::MASS_RST;
            r_tstep <= hsmd_pkg::TIMESTEP_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                hsmd_pkg::CFG_STIFFNESS: r_stiff <= i_cfg_wdata;
                hsmd_pkg::CFG_MASS:      r_mass  <= i_cfg_wdata;
                hsmd_pkg::CFG_TIMESTEP:  r_tstep <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hsmd_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequencer: next state, multiplier operands, divider start
    always_comb begin
        n_state    = r_state;
        mul_a      = '0;
        mul_b      = '0;
        mul_half   = 1'b0;
        div_start  = 1'b0;
        o_s_tready = 1'b0;
        unique case (r_state)
            hsmd_pkg::ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    n_state = hsmd_pkg::ST_KT;
                end
            end
            hsmd_pkg::ST_KT: begin
                mul_a   = $signed({1'b0, r_stiff});
                mul_b   = r_tstep;
                n_state = hsmd_pkg::ST_SPR;
            end
            hsmd_pkg::ST_SPR: begin
                mul_a   = r_da;
                mul_b   = r_stiff;
                n_state = hsmd_pkg::ST_DMP;
            end
            hsmd_pkg::ST_DMP: begin
                mul_a   = r_dv;
                mul_b   = r_damp[hsmd_pkg::REG_W-1:0];
                n_state = hsmd_pkg::ST_TRQ;
            end
            hsmd_pkg::ST_TRQ: begin
                mul_a   = r_speed;
                mul_b   = r_tstep;
                n_state = hsmd_pkg::ST_DST;
            end
            hsmd_pkg::ST_DST: begin
                div_start = 1'b1;
                n_state   = hsmd_pkg::ST_DIV;
            end
            hsmd_pkg::ST_DIV: begin
                if (div_done) begin
                    n_state = hsmd_pkg::ST_DV;
                end
            end
            hsmd_pkg::ST_DV: begin
                mul_a   = r_acc;
                mul_b   = r_tstep;
                n_state = hsmd_pkg::ST_DVC;
            end
            hsmd_pkg::ST_DVC: begin
                n_state = hsmd_pkg::ST_HF;
            end
            hsmd_pkg::ST_HF: begin
                mul_a    = r_dvel;
                mul_b    = r_tstep;
                mul_half = 1'b1;
                n_state  = hsmd_pkg::ST_UPD;
            end
            hsmd_pkg::ST_UPD: begin
                n_state = hsmd_pkg::ST_OUT;
            end
            hsmd_pkg::ST_OUT: begin
                if (out_free) begin
                    n_state = hsmd_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = hsmd_pkg::ST_IDLE;
            end
        endcase
    end

    // Working registers: capture each product but the half step in the state after the one that issues it
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_da <= hsmd_pkg::f_sat_sub(in_angle, r_pos);
            r_dv <= hsmd_pkg::f_sat_sub(in_vel, r_speed);
        end
        if (r_state == hsmd_pkg::ST_SPR) begin
            r_damp <= mul_res;
        end
        if (r_state == hsmd_pkg::ST_DMP) begin
            r_spring <= mul_res;
        end
        if (r_state == hsmd_pkg::ST_TRQ) begin
            r_torque <= hsmd_pkg::f_sat_add(r_spring, mul_res);
        end
        if (r_state == hsmd_pkg::ST_DST) begin
            r_vterm <= mul_res;
        end
        if (r_state == hsmd_pkg::ST_DIV && div_done) begin
            r_acc <= div_quo;
        end
        if (r_state == hsmd_pkg::ST_DVC) begin
            r_dvel <= mul_res;
        end
    end

    // Mass state: advance position and speed once per sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_speed <= '0;
        end else if (r_state == hsmd_pkg::ST_UPD) begin
            r_pos   <= hsmd_pkg::f_sat_add(hsmd_pkg::f_sat_add(r_pos, r_vterm), mul_res);
            r_speed <= hsmd_pkg::f_sat_add(r_speed, r_dvel);
        end
    end

    // Output register: load the torque when the slot is free, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (r_state == hsmd_pkg::ST_OUT && out_free) begin
            r_m_tvalid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == hsmd_pkg::ST_OUT && out_free) begin
            r_m_tdata <= r_torque;
        end
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;

endmodule

>>> hw/rtl/hsmd_mul.sv
// Shared Q16.16 multiplier: registered product, floor shift by 16 or 17, saturation.
module hsmd_mul (
    input  logic                            i_clk,
    input  logic signed [hsmd_pkg::Q_W-1:0] i_a,
    input  logic        [hsmd_pkg::REG_W-1:0] i_b,
    input  logic                            i_half,
    output logic signed [hsmd_pkg::Q_W-1:0] o_res
);

    localparam int unsigned PW = 2 * hsmd_pkg::Q_W;

    logic signed [2*hsmd_pkg::Q_W-1:0] r_prod;
    logic                              r_half;
    logic signed [2*hsmd_pkg::Q_W-1:0] shifted;

    // Register the full product and the shift choice that goes with it
    always_ff @(posedge i_clk) begin
        r_prod <= PW'(i_a) * PW'($signed({1'b0, i_b}));
        r_half <= i_half;
    end

    // Arithmetic shift rounds toward minus infinity, then clamp
    always_comb begin
        shifted = r_half ? (r_prod >>> 17) : (r_prod >>> 16);
        o_res   = hsmd_pkg::f_sat32(shifted[hsmd_pkg::WIDE_W-1:0]);
    end

endmodule

>>> hw/rtl/hsmd_div.sv
// Radix-4 restoring divider: saturated (torque << 16) / mass, truncated toward zero.
module hsmd_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [hsmd_pkg::Q_W-1:0]   i_num,
    input  logic        [hsmd_pkg::REG_W-1:0] i_den,
    output logic                              o_done,
    output logic signed [hsmd_pkg::Q_W-1:0]   o_quo
);

    localparam int unsigned NW = hsmd_pkg::DIV_NUM_W;
    localparam int unsigned RW = hsmd_pkg::REG_W;

    logic                           r_busy;
    logic                           r_done;
    logic [hsmd_pkg::DIV_CNT_W-1:0] r_cnt;
    logic [NW-1:0]                  r_nq;
    logic [RW-1:0]                  r_rem;
    logic [RW-1:0]                  r_den;
    logic                           r_neg;

    logic [NW-1:0]                  n_nq;
    logic [RW-1:0]                  n_rem;
    logic [RW:0]                    trial;
    logic [hsmd_pkg::Q_W-1:0]       mag;
    logic signed [hsmd_pkg::WIDE_W-1:0] wide_q;

    // Two restoring steps: numerator bits leave at the top, quotient bits enter at the bottom
    always_comb begin
        n_nq  = r_nq;
        n_rem = r_rem;
        for (int k = 0; k < hsmd_pkg::DIV_RADIX_W; k++) begin
            trial = {n_rem, n_nq[NW-1]};
            n_nq  = {n_nq[NW-2:0], 1'b0};
            if (trial >= {1'b0, r_den}) begin
                trial   = trial - {1'b0, r_den};
                n_nq[0] = 1'b1;
            end
            n_rem = trial[RW-1:0];
        end
    end

    // Magnitude of the dividend; the most negative value maps to 2^31
    assign mag = i_num[hsmd_pkg::Q_W-1] ? (~i_num + 1'b1) : i_num;

    // Control: start, count steps, flag completion for one cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == hsmd_pkg::DIV_CNT_W'(hsmd_pkg::DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_nq  <= {mag, {hsmd_pkg::DIV_FRAC_W{1'b0}}};
            r_rem <= '0;
            r_den <= i_den;
            r_neg <= i_num[hsmd_pkg::Q_W-1];
        end else if (r_busy) begin
            r_nq  <= n_nq;
            r_rem <= n_rem;
        end
    end

    // Apply sign and clamp
    always_comb begin
        wide_q = r_neg ? -$signed({1'b0, r_nq}) : $signed({1'b0, r_nq});
        o_quo  = hsmd_pkg::f_sat32(wide_q);
    end

    assign o_done = r_done;

endmodule

>>> hw/rtl/hsmd_chk.sv
// Port-level checker for the spring-mass-damper renderer, bound to the top level.
module hsmd_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [31:0] o_m_tdata
);

    // Reset empties the output register
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    // A stalled result holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result changed or vanished");

    // An accepted sample keeps the input closed while it is worked on
    a_busy: assert property (@(posedge i_clk)
        i_rst_n && i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("input ready straight after a transaction");

    // No result can appear the cycle after a sample is taken
    a_no_early: assert property (@(posedge i_clk)
        i_rst_n && i_s_tvalid && o_s_tready |=> !$rose(o_m_tvalid))
        else $error("result appeared too early");

endmodule

bind haptic_spring_mass_damper_tunable hsmd_chk u_hsmd_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

>>> sim/tb_top.sv
// Self-checking testbench for the spring-mass-damper haptic renderer.
`timescale 1ns / 1ps

module tb_top;

    localparam logic [hsmd_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;  // index past the register list
    localparam longint Q_HI = 64'sd2147483647;
    localparam longint Q_LO = -64'sd2147483648;
    localparam logic [hsmd_pkg::REG_W-1:0] REG_MAX = 31'h7FFF_FFFF;
    localparam int SAMPLES_PER_PHASE = 250;
    localparam int N_PHASES = 7;
    localparam int SETTLE_CYCLES = 40;

    typedef enum logic [0:0] {
        ROW_SAMPLE,
        ROW_WRITE
    } t_row_kind;

    typedef struct packed {
        t_row_kind                      kind;
        logic [hsmd_pkg::CFG_IDX_W-1:0] idx;
        logic [hsmd_pkg::REG_W-1:0]     wdata;
        logic [31:0]                    angle;
        logic [31:0]                    vel;
        logic                           typed;
        logic [31:0]                    torque;
    } t_plan_row;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_SPARSE,
        RX_BURSTY
    } t_rx_mode;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_s_tvalid = 1'b0;
    logic                           o_s_tready;
    logic [63:0]                    i_s_tdata = '0;
    logic                           o_m_tvalid;
    logic                           i_m_tready = 1'b0;
    logic [31:0]                    o_m_tdata;
    logic                           i_cfg_we = 1'b0;
    logic [hsmd_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [hsmd_pkg::REG_W-1:0]     i_cfg_wdata = '0;

    // Renderer copy: registers and simulated mass
    logic [hsmd_pkg::REG_W-1:0] k_cfg = hsmd_pkg::STIFFNESS_RST;
    logic [hsmd_pkg::REG_W-1:0] m_cfg = hsmd_pkg::MASS_RST;
    logic [hsmd_pkg::REG_W-1:0] t_cfg = hsmd_pkg::TIMESTEP_RST;
    int                         mass_pos_p = 0;
    int                         mass_spd_p = 0;

    logic [31:0] torque_due[$];
    int          fault_count = 0;
    int          burst_left = 0;

    haptic_spring_mass_damper_tunable DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    function automatic int clamp32(input longint x);
        if (x > Q_HI) return 32'sh7FFF_FFFF;
        if (x < Q_LO) return 32'sh8000_0000;
        return int'(x);
    endfunction

    // Q16.16 product, floor shift, then clamp
    function automatic int qmul(input int a, input longint b, input int s);
        return clamp32((longint'(a) * b) >>> s);
    endfunction

    // Torque for one sample, then advance the simulated mass
    function automatic logic [31:0] render_torque(input int angle, input int vel);
        longint m;
        int     da, dv, damp, spring_t, damp_t, torque, acc, dvel, vterm, half;
        m        = (m_cfg == '0) ? 64'sd1 : longint'(m_cfg);
        da       = clamp32(longint'(angle) - longint'(mass_pos_p));
        dv       = clamp32(longint'(vel) - longint'(mass_spd_p));
        damp     = clamp32((longint'(k_cfg) * longint'(t_cfg)) >>> 16);
        spring_t = qmul(da, longint'(k_cfg), 16);
        damp_t   = qmul(dv, longint'(damp), 16);
        torque   = clamp32(longint'(spring_t) + longint'(damp_t));
        acc      = clamp32((longint'(torque) * 64'sd65536) / m);
        dvel     = qmul(acc, longint'(t_cfg), 16);
        vterm    = qmul(mass_spd_p, longint'(t_cfg), 16);
        half     = qmul(dvel, longint'(t_cfg), 17);
        mass_pos_p = clamp32(longint'(clamp32(longint'(mass_pos_p) + longint'(vterm)))
                             + longint'(half));
        mass_spd_p = clamp32(longint'(mass_spd_p) + longint'(dvel));
        return torque;
    endfunction

    // Wheel value: mostly modest angles, some full-range and some extremes
    function automatic logic [31:0] pick_wheel();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel < 5) return $urandom_range(0, 32'h0080_0000) - 32'h0040_0000;
        if (sel < 8) return $urandom;
        case ($urandom_range(0, 4))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'h0000_0001;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    function automatic logic [hsmd_pkg::REG_W-1:0] pick_reg(
        input logic [hsmd_pkg::REG_W-1:0] rst_val);
        case ($urandom_range(0, 6))
            0: return '0;
            1: return REG_MAX;
            2: return rst_val;
            3: return hsmd_pkg::REG_W'($urandom_range(1, 32'h0004_0000));
            4: return hsmd_pkg::REG_W'($urandom_range(0, 32'h0100_0000));
            default: return hsmd_pkg::REG_W'($urandom);
        endcase
    endfunction

    // Present one sample, honouring the burst and gap pattern
    task automatic push_sample(input logic [31:0] angle, input logic [31:0] vel,
                               input logic typed, input logic [31:0] torque);
        int          gap;
        logic [31:0] predicted;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
            if (gap > 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {vel, angle};
        do @(posedge i_clk); while (!o_s_tready);
        burst_left--;
        predicted = render_torque(angle, vel);
        torque_due.push_back(typed ? torque : predicted);
    endtask

    // Hold off the sender until every outstanding torque has come back
    task automatic drain();
        i_s_tvalid <= 1'b0;
        burst_left = 0;
        while (torque_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [hsmd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [hsmd_pkg::REG_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            hsmd_pkg::CFG_STIFFNESS: k_cfg = val;
            hsmd_pkg::CFG_MASS:      m_cfg = val;
            hsmd_pkg::CFG_TIMESTEP:  t_cfg = val;
            default:                 ;
        endcase
        @(posedge i_clk);
    endtask

    // Receiver back-pressure: switch between open, sparse and bursty stalls
    t_rx_mode rx_mode = RX_OPEN;
    int       rx_mode_left = 0;
    int       rx_run_left = 0;

    always @(posedge i_clk) begin
        if (rx_mode_left == 0) begin
            rx_mode      <= t_rx_mode'($urandom_range(0, 2));
            rx_mode_left <= $urandom_range(50, 400);
        end else begin
            rx_mode_left <= rx_mode_left - 1;
        end
        case (rx_mode)
            RX_OPEN:   i_m_tready <= 1'b1;
            RX_SPARSE: i_m_tready <= ($urandom_range(0, 3) != 0);
            default: begin
                if (rx_run_left == 0) begin
                    i_m_tready  <= !i_m_tready;
                    rx_run_left <= $urandom_range(1, 12);
                end else begin
                    rx_run_left <= rx_run_left - 1;
                end
            end
        endcase
    end

    // Compare each torque transaction with the oldest expectation
    always @(posedge i_clk) begin
        logic [31:0] want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (torque_due.size() == 0) begin
                fault_count++;
                if (fault_count <= 10)
                    $display("unexpected torque %0d at %0t", $signed(o_m_tdata), $realtime);
            end else begin
                want = torque_due.pop_front();
                if (o_m_tdata !== want) begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display("torque mismatch at %0t: expected %0d got %0d", $realtime,
                                 $signed(want), $signed(o_m_tdata));
                end
            end
        end
    end

    // Stimulus: directed plan, then randomised phases
    initial begin
        t_plan_row plan[$];
        t_plan_row row;
        logic      idle;
        int        ph;
        int        n;

        plan.push_back('{ROW_SAMPLE, CFG_SPARE, '0, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0});
        plan.push_back('{ROW_SAMPLE, CFG_SPARE, '0, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1,
                         32'h7FFF_FFFF});
        plan.push_back('{ROW_SAMPLE, CFG_SPARE, '0, 32'h8000_0000, 32'h8000_0000, 1'b1,
                         32'h8000_0000});
        plan.push_back('{ROW_SAMPLE, CFG_SPARE, '0, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 32'h0});
        plan.push_back('{ROW_SAMPLE, CFG_SPARE, '0, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 32'h0});
        plan.push_back('{ROW_SAMPLE, CFG_SPARE, '0, 32'h0001_0000, 32'hFFFF_0000, 1'b0, 32'h0});
        // zero stiffness gives no torque at all
        plan.push_back('{ROW_WRITE, hsmd_pkg::CFG_STIFFNESS, '0, 32'h0, 32'h0, 1'b0, 32'h0});
        plan.push_back('{ROW_SAMPLE, CFG_SPARE, '0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 32'h0});
        plan.push_back('{ROW_WRITE, hsmd_pkg::CFG_STIFFNESS, REG_MAX, 32'h0, 32'h0, 1'b0,
                         32'h0});
        plan.push_back('{ROW_WRITE, hsmd_pkg::CFG_MASS, REG_MAX, 32'h0, 32'h0, 1'b0, 32'h0});
        plan.push_back('{ROW_WRITE, hsmd_pkg::CFG_TIMESTEP, REG_MAX, 32'h0, 32'h0, 1'b0,
                         32'h0});
        plan.push_back('{ROW_SAMPLE, CFG_SPARE, '0, 32'h0000_0001, 32'hFFFF_FFFF, 1'b0, 32'h0});
        plan.push_back('{ROW_SAMPLE, CFG_SPARE, '0, 32'hFFFF_FFFF, 32'h0000_0001, 1'b0, 32'h0});
        // zero mass acts as one LSB
        plan.push_back('{ROW_WRITE, hsmd_pkg::CFG_MASS, '0, 32'h0, 32'h0, 1'b0, 32'h0});
        plan.push_back('{ROW_SAMPLE, CFG_SPARE, '0, 32'h0000_0100, 32'h0000_0000, 1'b0, 32'h0});
        plan.push_back('{ROW_SAMPLE, CFG_SPARE, '0, 32'hFFFF_FF00, 32'h0000_0000, 1'b0, 32'h0});
        // zero timestep: no damping, mass frozen
        plan.push_back('{ROW_WRITE, hsmd_pkg::CFG_TIMESTEP, '0, 32'h0, 32'h0, 1'b0, 32'h0});
        plan.push_back('{ROW_WRITE, hsmd_pkg::CFG_STIFFNESS, 31'h0001_0000, 32'h0, 32'h0, 1'b0,
                         32'h0});
        plan.push_back('{ROW_SAMPLE, CFG_SPARE, '0, 32'h0002_0000, 32'h0003_0000, 1'b0, 32'h0});
        // write to an unused index must be dropped
        plan.push_back('{ROW_WRITE, CFG_SPARE, REG_MAX, 32'h0, 32'h0, 1'b0, 32'h0});
        plan.push_back('{ROW_SAMPLE, CFG_SPARE, '0, 32'h0001_0000, 32'h0000_0000, 1'b0, 32'h0});
        plan.push_back('{ROW_WRITE, hsmd_pkg::CFG_TIMESTEP, 31'd1, 32'h0, 32'h0, 1'b0, 32'h0});
        plan.push_back('{ROW_WRITE, hsmd_pkg::CFG_MASS, 31'd1, 32'h0, 32'h0, 1'b0, 32'h0});
        plan.push_back('{ROW_SAMPLE, CFG_SPARE, '0, 32'h1234_5678, 32'h9ABC_DEF0, 1'b0, 32'h0});
        plan.push_back('{ROW_SAMPLE, CFG_SPARE, '0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 32'h0});

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed plan; registers change only once the block is idle
        idle = 1'b1;
        foreach (plan[r]) begin
            row = plan[r];
            if (row.kind == ROW_WRITE) begin
                if (!idle) drain();
                cfg_write(row.idx, row.wdata);
                idle = 1'b1;
            end else begin
                push_sample(row.angle, row.vel, row.typed, row.torque);
                idle = 1'b0;
            end
        end

        // Random phases, each under a fresh register setting
        for (ph = 0; ph < N_PHASES; ph++) begin
            drain();
            if (ph == 0) begin
                cfg_write(hsmd_pkg::CFG_STIFFNESS, hsmd_pkg::STIFFNESS_RST);
                cfg_write(hsmd_pkg::CFG_MASS, hsmd_pkg::MASS_RST);
                cfg_write(hsmd_pkg::CFG_TIMESTEP, hsmd_pkg::TIMESTEP_RST);
            end else begin
                cfg_write(hsmd_pkg::CFG_STIFFNESS, pick_reg(hsmd_pkg::STIFFNESS_RST));
                cfg_write(hsmd_pkg::CFG_MASS, pick_reg(hsmd_pkg::MASS_RST));
                cfg_write(hsmd_pkg::CFG_TIMESTEP, pick_reg(hsmd_pkg::TIMESTEP_RST));
            end
            for (n = 0; n < SAMPLES_PER_PHASE; n++)
                push_sample(pick_wheel(), pick_wheel(), 1'b0, 32'h0);
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fault_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Hard stop if the handshakes never complete
    initial begin
        #20_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
